// ===== hdl/pidc_pkg.sv =====
// package: widths, limits and register map of the positional pid controller
`default_nettype none
package pidc_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_FRAC_BITS = 16;
    localparam int INTEGRAL_LIMIT = 10000;

    localparam int GAIN_W = 32;
    localparam int DRIVE_W = 32;
    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int SUM_W  = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int RAW_W  = ((ERR_W > SUM_W) ? ERR_W : SUM_W) + 1;
    localparam int DIFF_W = ERR_W + 1;
    localparam int MUL_W  = (DIFF_W > RAW_W) ? DIFF_W : RAW_W;
    localparam int PROD_W = GAIN_W + MUL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int ADDR_W = 4;

    localparam logic signed [RAW_W-1:0] SUM_HI = RAW_W'(INTEGRAL_LIMIT);
    localparam logic signed [RAW_W-1:0] SUM_LO = -RAW_W'(INTEGRAL_LIMIT);

    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = {1'b0, {(DRIVE_W-1){1'b1}}};
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = {1'b1, {(DRIVE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        REG_GAIN_P = 2'd0,
        REG_GAIN_I = 2'd1,
        REG_GAIN_D = 2'd2,
        REG_NONE   = 2'd3
    } t_reg_idx;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [GAIN_W-1:0]       t_gain;
    typedef logic signed [PROD_W-1:0]       t_prod;

endpackage
`default_nettype wire

// ===== hdl/pidc_in_if.sv =====
// interface: sample channel carrying measured and target words
`default_nettype none
interface pidc_in_if import pidc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample measured;
    t_sample target;

    modport source (output valid, output measured, output target, input ready);
    modport sink   (input valid, input measured, input target, output ready);
endinterface
`default_nettype wire

// ===== hdl/pidc_out_if.sv =====
// interface: result channel carrying drive and saturation flag
`default_nettype none
interface pidc_out_if import pidc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [DRIVE_W-1:0]  drive;
    logic                       drive_saturated;

    modport source (output valid, output drive, output drive_saturated, input ready);
    modport sink   (input valid, input drive, input drive_saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/positional_pid_integral_clamp.sv =====
// top level: positional pid controller with clamped integral, three-stage pipeline
//
//  channel   dir  handshake        payload
//  i_samp    in   valid / ready    measured, target
//  o_drive   out  valid / ready    drive, drive_saturated
//  apb       in   psel / penable   gain_p @0x0, gain_i @0x4, gain_d @0x8
//
// one word per cycle unless o_drive back-pressure holds the pipeline
// stage 1: error, clamped sum and difference, state update at accept
// stage 2: three 32 x 18 multiplies; stage 3: sum, floor shift, saturate
// each stage holds on its own, so bubbles close up under output stall
// synchronous active-low reset clears state, gains and valid bits
`default_nettype none
module positional_pid_integral_clamp import pidc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    pidc_in_if.sink                i_samp,
    pidc_out_if.source             o_drive,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    t_gain r_gain_p, r_gain_i, r_gain_d;
    t_reg_idx w_idx;
    logic w_wr;

    logic signed [ERR_W-1:0]  r_prev_err;
    logic signed [SUM_W-1:0]  r_err_sum;

    logic                     r_v1, r_v2, r_v3;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [DIFF_W-1:0] r_diff;
    t_prod                    r_prod_p, r_prod_i, r_prod_d;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                     r_sat;

    logic en1, en2, en3, w_acc;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [RAW_W-1:0]  w_raw;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [DIFF_W-1:0] n_diff;
    t_prod                    n_prod_p, n_prod_i, n_prod_d;
    logic signed [ACC_W-1:0]  w_acc_sum, w_shift;
    logic signed [DRIVE_W-1:0] n_drive;
    logic                     n_sat;

    // config port
    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        unique case (w_idx)
            REG_GAIN_P: prdata = r_gain_p;
            REG_GAIN_I: prdata = r_gain_i;
            REG_GAIN_D: prdata = r_gain_d;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= '0;
            r_gain_i <= '0;
            r_gain_d <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_GAIN_P: r_gain_p <= pwdata;
                REG_GAIN_I: r_gain_i <= pwdata;
                REG_GAIN_D: r_gain_d <= pwdata;
                default:    ;
            endcase
        end
    end

    // stage enables
    assign en3 = !r_v3 || o_drive.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_samp.ready = en1;
    assign w_acc = i_samp.valid && en1;

    // stage 1 logic
    always_comb begin
        n_err  = ERR_W'(i_samp.target) - ERR_W'(i_samp.measured);
        w_raw  = RAW_W'(r_err_sum) + RAW_W'(n_err);
        if (w_raw > SUM_HI) begin
            n_sum = SUM_W'(SUM_HI);
        end else if (w_raw < SUM_LO) begin
            n_sum = SUM_W'(SUM_LO);
        end else begin
            n_sum = SUM_W'(w_raw);
        end
        n_diff = DIFF_W'(n_err) - DIFF_W'(r_prev_err);
    end

    // stage 2 logic
    always_comb begin
        n_prod_p = PROD_W'(r_gain_p) * PROD_W'(r_err);
        n_prod_i = PROD_W'(r_gain_i) * PROD_W'(r_sum);
        n_prod_d = PROD_W'(r_gain_d) * PROD_W'(r_diff);
    end

    // stage 3 logic
    always_comb begin
        w_acc_sum = ACC_W'(r_prod_p) + ACC_W'(r_prod_i) + ACC_W'(r_prod_d);
        w_shift   = w_acc_sum >>> GAIN_FRAC_BITS;
        if (w_shift[ACC_W-1:DRIVE_W-1] == '0 || w_shift[ACC_W-1:DRIVE_W-1] == '1) begin
            n_drive = w_shift[DRIVE_W-1:0];
            n_sat   = 1'b0;
        end else begin
            n_drive = w_shift[ACC_W-1] ? DRIVE_MIN : DRIVE_MAX;
            n_sat   = 1'b1;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_prev_err <= '0;
            r_err_sum  <= '0;
        end else begin
            if (en1) r_v1 <= i_samp.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (w_acc) begin
                r_prev_err <= n_err;
                r_err_sum  <= n_sum;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_err  <= n_err;
            r_sum  <= n_sum;
            r_diff <= n_diff;
        end
        if (en2 && r_v1) begin
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
        end
        if (en3 && r_v2) begin
            r_drive <= n_drive;
            r_sat   <= n_sat;
        end
    end

    assign o_drive.valid           = r_v3;
    assign o_drive.drive           = r_drive;
    assign o_drive.drive_saturated = r_sat;

endmodule
`default_nettype wire

// ===== tb/tb_positional_pid_integral_clamp.sv =====
// testbench: positional pid controller with integral clamp, checked against a predictor of its own
`timescale 1ns / 100ps
module tb_positional_pid_integral_clamp;
    import pidc_pkg::*;

    typedef struct packed {
        t_sample measured;
        t_sample target;
    } t_sample_word;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      sat;
    } t_drive_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    pidc_in_if  samp ();
    pidc_out_if res ();

    positional_pid_integral_clamp DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_samp  (samp),
        .o_drive (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state and gains
    t_gain                      kp = '0;
    t_gain                      ki = '0;
    t_gain                      kd = '0;
    logic signed [ERR_W-1:0]    last_err = '0;
    logic signed [SUM_W-1:0]    integ_sum = '0;

    t_sample_word sample_q[$];
    t_drive_word  drive_q[$];
    t_sample_word next_word;
    t_drive_word  want;
    int           n_bad = 0;
    int           idle_pct = 9;
    int           track_set = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_drive_word pid_drive(t_sample meas, t_sample targ);
        logic signed [ERR_W-1:0]  err;
        logic signed [RAW_W-1:0]  sum_now;
        logic signed [DIFF_W-1:0] diff;
        logic signed [63:0]       acc;
        t_drive_word              w;
        err = ERR_W'(targ) - ERR_W'(meas);
        sum_now = RAW_W'(integ_sum) + RAW_W'(err);
        if (sum_now > SUM_HI) begin
            sum_now = SUM_HI;
        end
        if (sum_now < SUM_LO) begin
            sum_now = SUM_LO;
        end
        diff = DIFF_W'(err) - DIFF_W'(last_err);
        acc = 64'(kp) * 64'(err) + 64'(ki) * 64'(sum_now) + 64'(kd) * 64'(diff);
        acc = acc >>> GAIN_FRAC_BITS;
        w.sat = 1'b1;
        if (acc > DRIVE_MAX) begin
            w.drive = DRIVE_MAX;
        end else if (acc < DRIVE_MIN) begin
            w.drive = DRIVE_MIN;
        end else begin
            w.drive = acc[DRIVE_W-1:0];
            w.sat = 1'b0;
        end
        integ_sum = sum_now[SUM_W-1:0];
        last_err = err;
        return w;
    endfunction

    function automatic void add_item(t_sample m, t_sample t);
        t_sample_word s;
        s.measured = m;
        s.target = t;
        sample_q.push_back(s);
    endfunction

    function automatic t_sample extreme_sample();
        case ($urandom_range(3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    function automatic void add_random_item();
        int kind;
        int off;
        kind = $urandom_range(9);
        if (kind < 4) begin
            add_item(t_sample'($urandom), t_sample'($urandom));
        end else if (kind < 8) begin
            // setpoint tracking with small errors moves the integral only in small steps
            if ($urandom_range(15) == 0) begin
                track_set = $urandom_range(60000) - 30000;
            end
            off = $urandom_range(400) - 200;
            add_item(t_sample'(track_set + off), t_sample'(track_set));
        end else begin
            add_item(extreme_sample(), extreme_sample());
        end
    endfunction

    function automatic t_gain rand_gain();
        case ($urandom_range(3))
            0: return t_gain'($urandom);
            1: return t_gain'($urandom_range(1 << 19) - (1 << 18));
            2: begin
                case ($urandom_range(3))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0001_0000;
                    default: return '0;
                endcase
            end
            default: return t_gain'($urandom_range(1 << 25) - (1 << 24));
        endcase
    endfunction

    task automatic write_gain(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_P: kp = val;
            REG_GAIN_I: ki = val;
            REG_GAIN_D: kd = val;
            default: ;
        endcase
    endtask

    task automatic write_gains(t_gain p, t_gain i, t_gain d);
        write_gain(REG_GAIN_P, p);
        write_gain(REG_GAIN_I, i);
        write_gain(REG_GAIN_D, d);
    endtask

    task automatic drain();
        do @(negedge i_clk); while (sample_q.size() != 0 || samp.valid || drive_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            samp.valid <= 1'b0;
        end else begin
            if (samp.valid && samp.ready) begin
                drive_q.push_back(pid_drive(samp.measured, samp.target));
            end
            if (!samp.valid || samp.ready) begin
                if (sample_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    next_word = sample_q.pop_front();
                    samp.valid    <= 1'b1;
                    samp.measured <= next_word.measured;
                    samp.target   <= next_word.target;
                end else begin
                    samp.valid <= 1'b0;
                end
            end
        end
    end

    // drive monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(99) >= idle_pct);
            if (res.valid && res.ready) begin
                if (drive_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("unexpected drive word: drive %0d sat %0b",
                                 res.drive, res.drive_saturated);
                    end
                end else begin
                    want = drive_q.pop_front();
                    if (res.drive !== want.drive || res.drive_saturated !== want.sat) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("drive mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     want.drive, want.sat, res.drive, res.drive_saturated);
                        end
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unit p gain, i gain 0.25 and d gain 0.5, then a write to the unused slot that must change nothing
        write_gains(32'h0001_0000, 32'h0000_4000, 32'h0000_8000);
        write_gain(REG_NONE, 32'hDEAD_BEEF);
        add_item(16'sd0, 16'sd1000);
        add_item(16'sh8000, 16'sh7FFF);
        add_item(16'sh8000, 16'sh7FFF);
        add_item(16'sh7FFF, 16'sh8000);
        add_item(16'sh7FFF, 16'sh8000);
        add_item(16'sd0, 16'sd0);
        add_item(-16'sd1, -16'sd1);
        add_item(16'sh7FFF, 16'sh7FFF);
        add_item(16'sh8000, 16'sh8000);
        drain();

        // largest gains drive the output into both rails
        write_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(16'sh8000, 16'sh7FFF);
        add_item(16'sh7FFF, 16'sh8000);
        add_item(16'sd0, 16'sd0);
        add_item(16'sd5, 16'sd4);
        add_item(16'sd0, 16'sd0);
        drain();
        write_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_item(16'sh8000, 16'sh7FFF);
        add_item(16'sh7FFF, 16'sh8000);
        add_item(16'sd0, 16'sd0);
        add_item(16'sd3, 16'sd3);
        add_item(16'sh8000, 16'sh8000);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct = (ph == 2) ? 0 : 9;
            write_gains(rand_gain(), rand_gain(), rand_gain());
            repeat (105) add_random_item();
            drain();
        end
        idle_pct = 9;

        repeat (8) @(posedge i_clk);
        if (n_bad == 0 && drive_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pidc_pkg.sv
hdl/pidc_in_if.sv
hdl/pidc_out_if.sv
hdl/positional_pid_integral_clamp.sv
tb/tb_positional_pid_integral_clamp.sv
